// ===== rtl/radar_target_frame_parser_assert.svh =====
// assertion macros for the frame parser rtl
`ifndef RADAR_TARGET_FRAME_PARSER_ASSERT_SVH
`define RADAR_TARGET_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define RFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define RFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rfp_pkg.sv =====
// shared constants, types and field decode for the radar target frame parser
package rfp_pkg;

  localparam logic [7:0]  TRAIL_FIRST  = 8'h55;
  localparam logic [7:0]  TRAIL_SECOND = 8'hCC;
  localparam logic [15:0] SIGN_SPLIT   = 16'h8000;
  localparam int          HEADER_BYTES = 4;
  localparam int          TARGET_BYTES = 8;
  localparam int          SLOT_BITS    = 8 * TARGET_BYTES;

  typedef struct packed {
    logic load;
    logic shift;
  } slot_ctl_t;

  // raw below 0x8000 gives minus raw, otherwise raw minus 0x8000
  function automatic logic signed [15:0] decode_field(input logic [7:0] lo,
                                                      input logic [7:0] hi);
    logic [15:0] raw;
    logic [15:0] val;
    raw = {hi, lo};
    if (raw < SIGN_SPLIT) begin
      val = 16'd0 - raw;
    end else begin
      val = raw - SIGN_SPLIT;
    end
    return $signed(val);
  endfunction

endpackage

// ===== rtl/rfp_byte_cell.sv =====
// one byte cell of the receive window shift chain
module rfp_byte_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/rfp_slot_cell.sv =====
// one target slot of the result drain chain, parallel load or shift from neighbor
module rfp_slot_cell (
  input  logic                         clk,
  input  rfp_pkg::slot_ctl_t           ctl,
  input  logic [rfp_pkg::SLOT_BITS-1:0] load_data,
  input  logic [rfp_pkg::SLOT_BITS-1:0] shift_data,
  output logic [rfp_pkg::SLOT_BITS-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= load_data;
    end else if (ctl.shift) begin
      q <= shift_data;
    end
  end

endmodule

// ===== rtl/radar_target_frame_parser.sv =====
// top level of the tail-delimited radar target frame parser
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  rx      | in  | rx_valid / rx_stall  | rx_byte
//  res     | out | res_valid / res_stall| target_number, header_word, pos_x, pos_y,
//          |     |                      | speed, resolution, last_target
//
//  one byte a cycle is taken while rx_stall is low; the window is a chain of byte cells
//  that shifts on every stored byte, so a trailer sees the whole frame as it arrives
//  a frame is copied into a chain of target slots and drains through the single output
//  register, one result a cycle while that register is free
//  rx_stall is high while the previous frame still drains and the full window ends
//  in 0x55, so a completing trailer waits; frame spacing normally hides the drain
//  synchronous reset clears fill count, drain count and result valid; window and
//  slot bytes are not reset
//  res_stall holds the output register while res_valid is high; draining pauses with it
module radar_target_frame_parser #(
  parameter int TARGET_COUNT = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [1:0]         target_number,
  output logic [31:0]        header_word,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] speed,
  output logic signed [15:0] resolution,
  output logic               last_target
);

  `include "radar_target_frame_parser_assert.svh"

  // window holds header, all target fields and the first trailer byte
  localparam int WIN_DEPTH = rfp_pkg::HEADER_BYTES + rfp_pkg::TARGET_BYTES * TARGET_COUNT + 1;
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int CNT_W     = $clog2(TARGET_COUNT + 1);
  localparam int IDX_W     = (TARGET_COUNT > 1) ? $clog2(TARGET_COUNT) : 1;

  // window cells, index 0 oldest, WIN_DEPTH-1 newest
  logic [7:0]              win [WIN_DEPTH];
  logic [FILL_W-1:0]       fill_count;
  logic                    win_full;

  // drain side
  logic [rfp_pkg::SLOT_BITS-1:0] slot      [TARGET_COUNT];
  logic [rfp_pkg::SLOT_BITS-1:0] slot_load [TARGET_COUNT];
  logic [CNT_W-1:0]        remaining;
  logic [IDX_W-1:0]        emit_idx;
  logic [31:0]             header;
  rfp_pkg::slot_ctl_t      slot_ctl;

  logic rx_fire;
  logic trailer;
  logic push;
  logic frame_load;
  logic res_fire;
  logic out_free;
  logic emit;

  assign win_full = (fill_count == FILL_W'(WIN_DEPTH));

  // hold off a completing trailer while the previous frame still drains
  assign rx_stall = (remaining != '0) && win_full && (win[WIN_DEPTH-1] == rfp_pkg::TRAIL_FIRST);
  assign rx_fire  = rx_valid && !rx_stall;

  // 0x55 then 0xcc with at least one byte stored since the last clear
  assign trailer    = (rx_byte == rfp_pkg::TRAIL_SECOND) && (fill_count != '0) &&
                      (win[WIN_DEPTH-1] == rfp_pkg::TRAIL_FIRST);
  assign push       = rx_fire && !trailer;
  assign frame_load = rx_fire && trailer && win_full;

  // byte cell chain, new byte enters at the newest end
  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_win
    if (i == WIN_DEPTH - 1) begin : g_head
      rfp_byte_cell u_cell (.clk(clk), .shift(push), .d(rx_byte), .q(win[i]));
    end else begin : g_body
      rfp_byte_cell u_cell (.clk(clk), .shift(push), .d(win[i+1]), .q(win[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (rx_fire) begin
      if (trailer) begin
        fill_count <= '0;
      end else if (!win_full) begin
        fill_count <= fill_count + FILL_W'(1);
      end
    end
  end

  // output register handshake
  assign res_fire = res_valid && !res_stall;
  assign out_free = !res_valid || !res_stall;
  assign emit     = (remaining != '0) && out_free;

  assign slot_ctl.load  = frame_load;
  assign slot_ctl.shift = emit;

  // target slot chain, slot 0 feeds the output register
  for (genvar t = 0; t < TARGET_COUNT; t++) begin : g_slot
    for (genvar k = 0; k < rfp_pkg::TARGET_BYTES; k++) begin : g_byte
      assign slot_load[t][8*k +: 8] = win[rfp_pkg::HEADER_BYTES + rfp_pkg::TARGET_BYTES*t + k];
    end
    if (t == TARGET_COUNT - 1) begin : g_tail
      rfp_slot_cell u_slot (
        .clk(clk), .ctl(slot_ctl), .load_data(slot_load[t]),
        .shift_data(slot[t]), .q(slot[t])
      );
    end else begin : g_body
      rfp_slot_cell u_slot (
        .clk(clk), .ctl(slot_ctl), .load_data(slot_load[t]),
        .shift_data(slot[t+1]), .q(slot[t])
      );
    end
  end

  // header snapshot, first received byte on top
  always_ff @(posedge clk) begin
    if (frame_load) begin
      header <= {win[0], win[1], win[2], win[3]};
    end
  end

  // drain counters
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      emit_idx  <= '0;
    end else if (frame_load) begin
      remaining <= CNT_W'(TARGET_COUNT);
      emit_idx  <= '0;
    end else if (emit) begin
      remaining <= remaining - CNT_W'(1);
      emit_idx  <= emit_idx + IDX_W'(1);
    end
  end

  // result register, fields decoded from slot 0 as it leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_fire) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      target_number <= 2'(emit_idx);
      header_word   <= header;
      pos_x         <= rfp_pkg::decode_field(slot[0][7:0],   slot[0][15:8]);
      pos_y         <= rfp_pkg::decode_field(slot[0][23:16], slot[0][31:24]);
      speed         <= rfp_pkg::decode_field(slot[0][39:32], slot[0][47:40]);
      resolution    <= rfp_pkg::decode_field(slot[0][55:48], slot[0][63:56]);
      last_target   <= (remaining == CNT_W'(1));
    end
  end

  // a new frame never lands on top of one still draining
  `RFP_ASSERT_NOW(a_load_when_idle, frame_load, remaining == '0, "frame loaded while draining")
  // a loaded frame starts a full drain from the first target
  `RFP_ASSERT_NEXT(a_load_count, frame_load, (remaining == CNT_W'(TARGET_COUNT)) && (emit_idx == '0), "drain count wrong after load")
  // a taken result that is not the last is followed at once by the next one
  `RFP_ASSERT_NEXT(a_drain_gapless, res_fire && !last_target, res_valid, "gap inside frame drain")

endmodule

// ===== sim/radar_target_frame_parser_tb.sv =====
// self-checking testbench for the radar target frame parser
`timescale 1ns / 1ps

module radar_target_frame_parser_tb;

  localparam int TARGET_COUNT = 3;
  localparam int FRAME_LEN    = rfp_pkg::HEADER_BYTES + TARGET_COUNT * rfp_pkg::TARGET_BYTES;
  localparam int WIN_DEPTH    = FRAME_LEN + 1;
  localparam int CLK_PERIOD   = 4;
  localparam int HOLD_CYCLES  = 160;
  localparam int DRAIN_CYCLES = 24;
  localparam int TIMEOUT_NS   = 400_000;
  localparam int RANDOM_BYTES = 40;
  localparam int HOLD_FRAMES  = 3;

  // one result beat as it leaves the block
  typedef struct packed {
    logic [1:0]         target_number;
    logic [31:0]        header_word;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] speed;
    logic signed [15:0] resolution;
    logic               last_target;
  } target_beat_t;

  // one directed frame shape: lead byte, body of header plus lo/hi field pairs, trailer
  // where typed is set the expected beats are spelled out in the row itself
  typedef struct packed {
    logic [31:0]        hdr;
    logic [7:0]         lo;
    logic [7:0]         hi;
    int                 body;
    bit                 lead_on;
    logic [7:0]         lead;
    bit                 trail;
    bit                 typed;
    int                 exp_n;
    logic signed [15:0] exp_val;
  } frame_row_t;

  localparam int ROW_COUNT = 13;

  frame_row_t frame_rows [ROW_COUNT] = '{
    // lone 0xcc right after reset, all-zero frame
    '{32'h0000_0000, 8'h00, 8'h00, 28, 1'b1, rfp_pkg::TRAIL_SECOND, 1'b1, 1'b1, 3, 16'sh0000},
    // all ones
    '{32'hFFFF_FFFF, 8'hFF, 8'hFF, 28, 1'b0, 8'h00, 1'b1, 1'b1, 3, 16'sh7FFF},
    // raw exactly at the sign split
    '{32'h1234_5678, 8'h00, 8'h80, 28, 1'b0, 8'h00, 1'b1, 1'b1, 3, 16'sh0000},
    // largest raw below the split
    '{32'hA5A5_A5A5, 8'hFF, 8'h7F, 28, 1'b0, 8'h00, 1'b1, 1'b1, 3, -16'sh7FFF},
    // raw one, header full of 0x55 bytes
    '{32'h5555_5555, 8'h01, 8'h00, 28, 1'b0, 8'h00, 1'b1, 1'b1, 3, -16'sh0001},
    // 0xcc straight after a trailer is plain data
    '{32'h0F0F_0F0F, 8'h01, 8'h80, 28, 1'b1, rfp_pkg::TRAIL_SECOND, 1'b1, 1'b1, 3, 16'sh0001},
    // short frame, one byte missing
    '{32'h0000_0000, 8'h11, 8'h22, 27, 1'b0, 8'h00, 1'b1, 1'b1, 0, 16'sh0000},
    // bare trailer right after a clear
    '{32'h0000_0000, 8'h00, 8'h00, 0, 1'b0, 8'h00, 1'b1, 1'b1, 0, 16'sh0000},
    // long run with filler ahead, 0xcc after other bytes stays data
    '{32'hC3C3_C3C3, rfp_pkg::TRAIL_SECOND, 8'h12, 33, 1'b0, 8'h00, 1'b1, 1'b1, 3, -16'sh12CC},
    // partial frame ending in 0x55, no trailer
    '{32'h0000_0000, 8'h00, rfp_pkg::TRAIL_FIRST, 12, 1'b0, 8'h00, 1'b0, 1'b0, 0, 16'sh0000},
    // lead 0xcc completes a short trailer, then a full frame
    '{32'h0102_0304, 8'h34, 8'h92, 28, 1'b1, rfp_pkg::TRAIL_SECOND, 1'b1, 1'b0, 0, 16'sh0000},
    // 0x55 0x55 0xcc at the tail
    '{32'h89AB_CDEF, 8'h00, rfp_pkg::TRAIL_FIRST, 28, 1'b0, 8'h00, 1'b1, 1'b0, 0, 16'sh0000},
    // one spare byte ahead of the frame
    '{32'h8000_0001, 8'h80, 8'h00, 29, 1'b0, 8'h00, 1'b1, 1'b0, 0, 16'sh0000}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               rx_valid = 1'b0;
  logic               rx_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [1:0]         target_number;
  logic [31:0]        header_word;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] speed;
  logic signed [15:0] resolution;
  logic               last_target;

  // byte window and fill count of the predictor
  logic [7:0]   rx_window [WIN_DEPTH];
  int           window_fill = 0;
  target_beat_t pending_targets [$];
  int           mismatches = 0;

  // idling controls for the sender and the receiver
  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;
  bit hold_req = 1'b0;

  radar_target_frame_parser #(
    .TARGET_COUNT(TARGET_COUNT)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .target_number(target_number),
    .header_word  (header_word),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .speed        (speed),
    .resolution   (resolution),
    .last_target  (last_target)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // advances the window by one accepted byte and queues the target beats it releases;
  // on a typed trailer the row's own expectation replaces the computed one
  task automatic track_byte(input logic [7:0] b, input bit typed, input int exp_n,
                            input logic [31:0] exp_hdr, input logic signed [15:0] exp_val);
    target_beat_t beat;
    logic [15:0]  raw;
    logic [15:0]  val [4];
    int           base;
    bit           trailer;
    trailer = (b == rfp_pkg::TRAIL_SECOND) && (window_fill != 0) &&
              (rx_window[WIN_DEPTH-1] == rfp_pkg::TRAIL_FIRST);
    // full window ending in the 0x55: decode every target slot
    if (trailer && window_fill == WIN_DEPTH && !typed) begin
      for (int t = 0; t < TARGET_COUNT; t++) begin
        base = rfp_pkg::HEADER_BYTES + t * rfp_pkg::TARGET_BYTES;
        for (int f = 0; f < 4; f++) begin
          raw = {rx_window[base + 2*f + 1], rx_window[base + 2*f]};
          val[f] = (raw < rfp_pkg::SIGN_SPLIT) ? 16'd0 - raw : raw - rfp_pkg::SIGN_SPLIT;
        end
        beat.target_number = t[1:0];
        beat.header_word   = {rx_window[0], rx_window[1], rx_window[2], rx_window[3]};
        beat.pos_x         = val[0];
        beat.pos_y         = val[1];
        beat.speed         = val[2];
        beat.resolution    = val[3];
        beat.last_target   = (t == TARGET_COUNT - 1);
        pending_targets = {pending_targets, beat};
      end
    end
    if (typed) begin
      for (int t = 0; t < exp_n; t++) begin
        beat.target_number = t[1:0];
        beat.header_word   = exp_hdr;
        beat.pos_x         = exp_val;
        beat.pos_y         = exp_val;
        beat.speed         = exp_val;
        beat.resolution    = exp_val;
        beat.last_target   = (t == exp_n - 1);
        pending_targets = {pending_targets, beat};
      end
    end
    // the 0xcc of a trailer is dropped and the store cleared; anything else shifts in
    if (trailer) begin
      window_fill = 0;
    end else begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        rx_window[i] = rx_window[i+1];
      end
      rx_window[WIN_DEPTH-1] = b;
      if (window_fill < WIN_DEPTH) begin
        window_fill++;
      end
    end
  endtask

  // offers one byte, waits for the beat to be taken, then updates the predictor
  task automatic send_byte(input logic [7:0] b, input bit typed, input int exp_n,
                           input logic [31:0] exp_hdr, input logic signed [15:0] exp_val);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      rx_valid <= 1'b0;
      rx_byte  <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    track_byte(b, typed, exp_n, exp_hdr, exp_val);
  endtask

  // a typed expectation only ever rides on the final byte of the sequence
  task automatic send_seq(input logic [7:0] seq [$], input bit typed, input int exp_n,
                          input logic [31:0] exp_hdr, input logic signed [15:0] exp_val);
    foreach (seq[i]) begin
      send_byte(seq[i], typed && (i == seq.size() - 1), exp_n, exp_hdr, exp_val);
    end
  endtask

  // random byte leaning toward the trailer codes and field extremes
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0: b = rfp_pkg::TRAIL_FIRST;
        1: b = rfp_pkg::TRAIL_SECOND;
        2: b = 8'h00;
        3: b = 8'hFF;
        4: b = 8'h80;
        default: b = 8'h7F;
      endcase
    end
    return b;
  endfunction

  // well-formed frame with random content, optionally preceded by spare bytes
  task automatic send_random_frame(input int spare);
    logic [7:0] seq [$];
    for (int i = 0; i < FRAME_LEN + spare; i++) begin
      seq = {seq, pick_byte()};
    end
    seq = {seq, rfp_pkg::TRAIL_FIRST};
    seq = {seq, rfp_pkg::TRAIL_SECOND};
    send_seq(seq, 1'b0, 0, 32'h0, 16'sh0);
  endtask

  // scoreboard: every taken result beat is matched against the oldest expectation
  function automatic void note_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %h got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : res_check
    target_beat_t w;
    if (!rst && res_valid && !res_stall) begin
      if (pending_targets.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatches++;
      end else begin
        w = pending_targets.pop_front();
        note_field("target_number", 32'(w.target_number), 32'(target_number));
        note_field("header_word", w.header_word, header_word);
        note_field("pos_x", 32'(w.pos_x), 32'(pos_x));
        note_field("pos_y", 32'(w.pos_y), 32'(pos_y));
        note_field("speed", 32'(w.speed), 32'(speed));
        note_field("resolution", 32'(w.resolution), 32'(resolution));
        note_field("last_target", 32'(w.last_target), 32'(last_target));
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // stimulus: directed rows, back-pressure burst, random traffic, quiet tail
  initial begin : stimulus
    logic [7:0] seq [$];
    frame_row_t row;
    int         q;
    int         random_bytes;
    int         kind;
    int         n;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed rows: bytes older than the last frame-length are filler
    for (int r = 0; r < ROW_COUNT; r++) begin
      row = frame_rows[r];
      seq.delete();
      if (row.lead_on) begin
        seq = {seq, row.lead};
      end
      for (int p = 0; p < row.body; p++) begin
        q = p - (row.body - FRAME_LEN);
        if (q < 0) begin
          seq = {seq, 8'hA5};
        end else if (q < rfp_pkg::HEADER_BYTES) begin
          seq = {seq, row.hdr[31 - 8*q -: 8]};
        end else begin
          seq = {seq, ((q - rfp_pkg::HEADER_BYTES) % 2 == 0) ? row.lo : row.hi};
        end
      end
      if (row.trail) begin
        seq = {seq, rfp_pkg::TRAIL_FIRST};
        seq = {seq, rfp_pkg::TRAIL_SECOND};
      end
      send_seq(seq, row.typed && row.trail, row.exp_n, row.hdr, row.exp_val);
    end

    // receiver holds off while frames keep coming back to back,
    // so the drain chain fills and the input has to stall
    sender_gaps = 1'b0;
    hold_req = 1'b1;
    for (int f = 0; f < HOLD_FRAMES; f++) begin
      send_random_frame(0);
    end
    sender_gaps = 1'b1;

    // random traffic: mostly full frames, some short frames and loose noise
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      seq.delete();
      if (kind < 65) begin
        n = ($urandom_range(0, 3) == 0) ? FRAME_LEN + $urandom_range(1, 8) : FRAME_LEN;
        for (int i = 0; i < n; i++) begin
          seq = {seq, pick_byte()};
        end
        seq = {seq, rfp_pkg::TRAIL_FIRST};
        seq = {seq, rfp_pkg::TRAIL_SECOND};
      end else if (kind < 80) begin
        n = $urandom_range(0, FRAME_LEN - 1);
        for (int i = 0; i < n; i++) begin
          seq = {seq, pick_byte()};
        end
        seq = {seq, rfp_pkg::TRAIL_FIRST};
        seq = {seq, rfp_pkg::TRAIL_SECOND};
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          seq = {seq, pick_byte()};
        end
      end
      send_seq(seq, 1'b0, 0, 32'h0, 16'sh0);
      random_bytes += seq.size();
    end

    // quiet tail: full rate on both sides
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    send_random_frame(1);
    rx_valid <= 1'b0;

    while (pending_targets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_targets.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
